// ----- hw/rtl/tlx_pkg.sv -----
// ----------------------------------------------------------------------------
// tlx_pkg
// Shared types, codes and keyword table for the token lexer stream.
// ----------------------------------------------------------------------------
package tlx_pkg;

	// text limits
	localparam int MAX_TEXT = 8192;
	localparam int POS_W    = $clog2(MAX_TEXT) + 1;
	localparam int START_W  = 13;
	localparam int LEN_W    = 14;
	localparam int KIND_W   = 3;
	localparam int KW_W     = 4;
	localparam int MODE_W   = 4;
	localparam int WORD_W   = 64;
	localparam int RES_MAX  = 3;

	// result queue
	localparam int Q_DEPTH = 8;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);
	localparam int Q_ROOM  = Q_DEPTH - RES_MAX;

	// lexer modes
	localparam logic [MODE_W-1:0] M_IDLE    = 4'd0;
	localparam logic [MODE_W-1:0] M_IDENT   = 4'd1;
	localparam logic [MODE_W-1:0] M_INT     = 4'd2;
	localparam logic [MODE_W-1:0] M_MINUS   = 4'd3;
	localparam logic [MODE_W-1:0] M_SLASH   = 4'd4;
	localparam logic [MODE_W-1:0] M_COMMENT = 4'd5;
	localparam logic [MODE_W-1:0] M_STR     = 4'd6;
	localparam logic [MODE_W-1:0] M_EQ      = 4'd7;
	localparam logic [MODE_W-1:0] M_BANG    = 4'd8;

	// token kinds
	localparam logic [KIND_W-1:0] K_STR   = 3'd0;
	localparam logic [KIND_W-1:0] K_INT   = 3'd1;
	localparam logic [KIND_W-1:0] K_SYM   = 3'd2;
	localparam logic [KIND_W-1:0] K_KW    = 3'd3;
	localparam logic [KIND_W-1:0] K_IDENT = 3'd4;
	localparam logic [KIND_W-1:0] K_END   = 3'd5;
	localparam logic [KIND_W-1:0] K_ERR   = 3'd6;

	localparam logic [KW_W-1:0] KW_NONE = 4'd0;

	// source characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_LBRC  = 8'h7b;
	localparam logic [7:0] CH_RBRC  = 8'h7d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_UNDER = 8'h5f;

	// keywords, first byte in the lowest bits, zero padded
	localparam int N_KW = 9;
	localparam logic [WORD_W-1:0] KW_WORD [N_KW] = '{
		64'h0000_0000_0074_6573,  // set
		64'h0000_0000_6c6c_6163,  // call
		64'h7465_735f_6c6c_6163,  // call, underscore, set
		64'h0000_6e72_7574_6572,  // return
		64'h0000_0065_6c69_6877,  // while
		64'h0000_0000_6573_6163,  // case
		64'h0000_0000_0072_6176,  // var
		64'h0000_0000_636e_7566,  // func
		64'h0000_0000_746d_635f   // _cmt
	};
	localparam logic [LEN_W-1:0] KW_LEN [N_KW] = '{
		14'd3, 14'd4, 14'd8, 14'd6, 14'd5, 14'd4, 14'd3, 14'd4, 14'd4
	};

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [START_W-1:0] start_res;
		logic [LEN_W-1:0]   length;
		logic [KW_W-1:0]    keyword;
	} res_t;

	// results of one byte
	typedef struct packed {
		logic [1:0]             n;
		res_t [RES_MAX-1:0]     r;
	} step_out_t;

	// lexer state
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [POS_W-1:0]   pos;
		logic [START_W-1:0] ts;
		logic [LEN_W-1:0]   tl;
		logic [WORD_W-1:0]  wb;
		logic               halted;
	} lex_state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || (c == CH_UNDER);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_lower(c) || is_digit(c);
	endfunction

	// keyword code of a buffered word, none when no exact match
	function automatic logic [KW_W-1:0] kw_code(input logic [LEN_W-1:0] tl,
		input logic [WORD_W-1:0] wb);
		logic [KW_W-1:0] code;
		code = KW_NONE;
		for (int k = 0; k < N_KW; k++) begin
			if ((tl == KW_LEN[k]) && (wb == KW_WORD[k]))
				code = KW_W'(k + 1);
		end
		return code;
	endfunction

	function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
		input logic [START_W-1:0] start, input logic [LEN_W-1:0] len,
		input logic [KW_W-1:0] kw);
		res_t r;
		r.kind      = kind;
		r.start_res = start;
		r.length    = len;
		r.keyword   = kw;
		return r;
	endfunction

endpackage

// ----- hw/rtl/tlx_step.sv -----
// ----------------------------------------------------------------------------
// tlx_step
// Next lexer state and up to three result items for one source byte.
// ----------------------------------------------------------------------------
module tlx_step (
	input  logic [7:0]          ch,
	input  logic                last,
	input  tlx_pkg::lex_state_t st,
	output tlx_pkg::lex_state_t nxt,
	output tlx_pkg::step_out_t  res
);
	import tlx_pkg::*;

	lex_state_t       s;
	logic [1:0]       n;
	res_t [RES_MAX-1:0] r;
	logic             start_new;
	logic [KW_W-1:0]  kw_old;
	logic [KW_W-1:0]  kw_new;
	logic [START_W-1:0] p;

	assign kw_old = kw_code(st.tl, st.wb);
	assign p      = st.pos[START_W-1:0];

	// one byte through the mode logic, then the end of text
	always_comb begin
		s         = st;
		n         = 2'd0;
		r         = '0;
		start_new = 1'b0;
		kw_new    = KW_NONE;
		if (!st.halted) begin
			if (st.pos >= POS_W'(MAX_TEXT)) begin
				// text too long
				r[n]     = mk_res(K_ERR, START_W'(MAX_TEXT - 1), '0, KW_NONE);
				n        = n + 2'd1;
				s.halted = 1'b1;
				s.mode   = M_IDLE;
			end else begin
				s.pos = st.pos + POS_W'(1);
				// continue or close the open token
				case (st.mode)
					M_IDENT: begin
						if (is_word(ch)) begin
							if (st.tl < LEN_W'(8))
								s.wb[{st.tl[2:0], 3'b000} +: 8] = ch;
							s.tl = st.tl + LEN_W'(1);
						end else begin
							r[n] = mk_res((kw_old != KW_NONE) ? K_KW : K_IDENT,
								st.ts, st.tl, kw_old);
							n         = n + 2'd1;
							s.mode    = M_IDLE;
							start_new = 1'b1;
						end
					end
					M_INT: begin
						if (is_digit(ch)) begin
							s.tl = st.tl + LEN_W'(1);
						end else begin
							r[n]      = mk_res(K_INT, st.ts, st.tl, KW_NONE);
							n         = n + 2'd1;
							s.mode    = M_IDLE;
							start_new = 1'b1;
						end
					end
					M_MINUS: begin
						if (is_digit(ch)) begin
							s.tl   = st.tl + LEN_W'(1);
							s.mode = M_INT;
						end else begin
							r[n]     = mk_res(K_ERR, st.ts, LEN_W'(1), KW_NONE);
							n        = n + 2'd1;
							s.halted = 1'b1;
							s.mode   = M_IDLE;
						end
					end
					M_SLASH: begin
						if (ch == CH_SLASH) begin
							s.mode = M_COMMENT;
						end else begin
							r[n]     = mk_res(K_ERR, st.ts, LEN_W'(1), KW_NONE);
							n        = n + 2'd1;
							s.halted = 1'b1;
							s.mode   = M_IDLE;
						end
					end
					M_COMMENT: begin
						if (ch == CH_NL)
							s.mode = M_IDLE;
					end
					M_STR: begin
						if (ch == CH_QUOTE) begin
							r[n]   = mk_res(K_STR, st.ts, st.tl, KW_NONE);
							n      = n + 2'd1;
							s.mode = M_IDLE;
						end else begin
							s.tl = st.tl + LEN_W'(1);
						end
					end
					M_EQ: begin
						if (ch == CH_EQ) begin
							r[n] = mk_res(K_SYM, st.ts, LEN_W'(2), KW_NONE);
						end else begin
							r[n]      = mk_res(K_SYM, st.ts, LEN_W'(1), KW_NONE);
							start_new = 1'b1;
						end
						n      = n + 2'd1;
						s.mode = M_IDLE;
					end
					M_BANG: begin
						if (ch == CH_EQ) begin
							r[n]   = mk_res(K_SYM, st.ts, LEN_W'(2), KW_NONE);
							s.mode = M_IDLE;
						end else begin
							r[n]     = mk_res(K_ERR, st.ts, LEN_W'(1), KW_NONE);
							s.halted = 1'b1;
							s.mode   = M_IDLE;
						end
						n = n + 2'd1;
					end
					default: begin
						s.mode    = M_IDLE;
						start_new = 1'b1;
					end
				endcase

				// open a new token on this byte
				if (start_new && (ch != CH_SPACE) && (ch != CH_NL)) begin
					s.ts = p;
					s.tl = LEN_W'(1);
					case (ch)
						CH_SLASH: s.mode = M_SLASH;
						CH_QUOTE: begin
							s.mode = M_STR;
							s.ts   = p + START_W'(1);
							s.tl   = '0;
						end
						CH_MINUS: s.mode = M_MINUS;
						CH_EQ:    s.mode = M_EQ;
						CH_BANG:  s.mode = M_BANG;
						CH_SEMI, CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC,
						CH_COMMA, CH_PLUS, CH_STAR: begin
							r[n] = mk_res(K_SYM, p, LEN_W'(1), KW_NONE);
							n    = n + 2'd1;
						end
						default: begin
							if (is_digit(ch)) begin
								s.mode = M_INT;
							end else if (is_lower(ch)) begin
								s.mode = M_IDENT;
								s.wb   = {{(WORD_W-8){1'b0}}, ch};
							end else begin
								// stray byte
								r[n]     = mk_res(K_ERR, p, LEN_W'(1), KW_NONE);
								n        = n + 2'd1;
								s.halted = 1'b1;
								s.mode   = M_IDLE;
							end
						end
					endcase
				end

				// end of text: close the pending token, then the end item
				if (last && !s.halted) begin
					kw_new = kw_code(s.tl, s.wb);
					case (s.mode)
						M_IDENT: begin
							r[n] = mk_res((kw_new != KW_NONE) ? K_KW : K_IDENT,
								s.ts, s.tl, kw_new);
							n = n + 2'd1;
						end
						M_INT: begin
							r[n] = mk_res(K_INT, s.ts, s.tl, KW_NONE);
							n    = n + 2'd1;
						end
						M_MINUS, M_SLASH, M_BANG: begin
							r[n]     = mk_res(K_ERR, s.ts, LEN_W'(1), KW_NONE);
							n        = n + 2'd1;
							s.halted = 1'b1;
						end
						M_STR: begin
							// unterminated string, from the opening quote
							r[n] = mk_res(K_ERR, s.ts - START_W'(1), s.tl + LEN_W'(1),
								KW_NONE);
							n        = n + 2'd1;
							s.halted = 1'b1;
						end
						M_EQ: begin
							r[n] = mk_res(K_SYM, s.ts, LEN_W'(1), KW_NONE);
							n    = n + 2'd1;
						end
						default: ;
					endcase
					s.mode = M_IDLE;
					if (!s.halted) begin
						r[n] = mk_res(K_END, '0, LEN_W'(s.pos), KW_NONE);
						n    = n + 2'd1;
						s.pos = '0;
						s.ts  = '0;
						s.tl  = '0;
						s.wb  = '0;
					end
				end
			end
		end
		nxt   = s;
		res.n = n;
		res.r = r;
	end

endmodule

// ----- hw/rtl/tlx_outq.sv -----
// ----------------------------------------------------------------------------
// tlx_outq
// Result queue: up to three items in at once, one out per cycle on out_ready.
// ----------------------------------------------------------------------------
module tlx_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tlx_pkg::step_out_t din,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output tlx_pkg::res_t      out_res,
	output logic               out_last
);
	import tlx_pkg::*;

	res_t            mem_q  [Q_DEPTH];
	logic            last_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;
	logic            pop;
	logic [1:0]      n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem_q[rd_q];
	assign out_last  = last_q[rd_q];
	assign room      = (cnt_q <= Q_CW'(Q_ROOM));
	assign n_push    = push ? din.n : 2'd0;

	// entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (push && (2'(i) < din.n)) begin
				mem_q[wr_q + Q_AW'(i)]  <= din.r[i];
				last_q[wr_q + Q_AW'(i)] <= (2'(i) == din.n - 2'd1);
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + Q_AW'(n_push);
			if (pop)
				rd_q <= rd_q + Q_AW'(1);
			cnt_q <= cnt_q + Q_CW'(n_push) - Q_CW'(pop);
		end
	end

endmodule

// ----- hw/rtl/token_lexer_stream.sv -----
// ----------------------------------------------------------------------------
// token_lexer_stream
// Streaming lexer: source bytes in, token descriptors out.
//
// channel  dir  data                                         user      last
// s_axis   in   ch[7:0]                                      -         end_of_text
// m_axis   out  start_res[12:0] length[26:13] keyword[30:27]  kind[2:0] last_of_run
//
// A byte is registered on acceptance and lexed from that register once the
// queue has room; its results are written into an eight-entry queue and shown
// from there. One byte per cycle is taken while the queue holds at most five
// items; the queue drains one item per cycle while m_axis_tready is high, so
// bytes that give several results hold off the input for as long. Reset
// clears the lexer state, the input stage and the queue. After an error item
// the block keeps taking bytes and drops them until reset.
// ----------------------------------------------------------------------------
module token_lexer_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // ch
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // start_res, length, keyword, zero pad
	output logic [2:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast
);
	import tlx_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	lex_state_t st_q;
	lex_state_t st_nxt;
	step_out_t  step_res;
	logic       room;
	logic       go;
	res_t       out_res;

	assign go            = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || go;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// lexer state, idle mode is code zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (go) begin
			st_q <= st_nxt;
		end
	end

	tlx_step u_step (
		.ch   (ch_s1),
		.last (last_s1),
		.st   (st_q),
		.nxt  (st_nxt),
		.res  (step_res)
	);

	tlx_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.din       (step_res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res),
		.out_last  (m_axis_tlast)
	);

	// output packing
	assign m_axis_tdata = {1'b0, out_res.keyword, out_res.length, out_res.start_res};
	assign m_axis_tuser = out_res.kind;

endmodule
